### hdl/sat_pkg.sv
// Shared types and codes for the sorted array table.
// No dependencies; imported by every module of the block.
package sat_pkg;
    typedef enum logic [2:0] {
        CMD_SORTED_INSERT = 3'd0,
        CMD_INSERT_AT     = 3'd1,
        CMD_DELETE_VALUE  = 3'd2,
        CMD_DELETE_AT     = 3'd3,
        CMD_SEARCH        = 3'd4,
        CMD_READ          = 3'd5,
        CMD_CLEAR         = 3'd6,
        CMD_SORT          = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_DUP  = 2'd2,
        ST_MISS = 2'd3
    } status_t;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned POS_W   = 4;

    typedef struct packed {
        cmd_t               cmd;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   position;
    } item_t;

    typedef struct packed {
        status_t            status;
        logic               found;
        logic [VALUE_W-1:0] read_value;
        logic [4:0]         entry_count;
    } result_t;
endpackage

### hdl/sorted_array_table.sv
// Top level of the sorted array table: configuration register, front queue, back end.
// Depends on sat_pkg, sat_front, sat_back.
// Each command is carried out in the cell row, with every cell comparing and shifting
// in parallel; sort runs CAPACITY odd-even transposition passes. A two-item queue
// separates intake from execution, and a result register holds each result
// until taken. No clearing pass after reset.
module sorted_array_table #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data,       // descending_order
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,        // cmd[2:0], value[34:3], position[38:35]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata         // status[1:0], found[2], read_value[34:3], entry_count[39:35]
);
    import sat_pkg::*;

    logic    desc_reg;
    logic    q_valid, q_ready;
    item_t   in_item, q_item;
    result_t res;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) desc_reg <= 1'b0;
        else if (cfg_valid) desc_reg <= cfg_data[0];
    end

    assign in_item.cmd      = cmd_t'(s_tdata[2:0]);
    assign in_item.value    = s_tdata[34:3];
    assign in_item.position = s_tdata[38:35];

    sat_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_item,
        .q_valid, .q_ready, .q_item
    );

    sat_back #(.CAPACITY(CAPACITY)) u_back (
        .aclk, .aresetn, .descending_order(desc_reg),
        .q_valid, .q_ready, .q_item,
        .out_valid(m_tvalid), .out_ready(m_tready), .out_result(res)
    );

    assign m_tdata = {res.entry_count, res.read_value, res.found, res.status};
endmodule

### hdl/sat_front.sv
// Input side of the sorted array table: two-entry item queue.
// Depends on sat_pkg.
module sat_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  sat_pkg::item_t in_item,
    output logic           q_valid,
    input  logic           q_ready,
    output sat_pkg::item_t q_item
);
    import sat_pkg::*;

    item_t      slot_reg [2];
    logic       wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
        if (push) begin
            slot_reg[wptr_reg] <= in_item;
        end
    end
endmodule

### hdl/sat_back.sv
// Execution side of the sorted array table: cell row with broadcast compare/shift,
// odd-even transposition sort, output register. Depends on sat_pkg.
module sat_back #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             descending_order,
    input  logic             q_valid,
    output logic             q_ready,
    input  sat_pkg::item_t   q_item,
    output logic             out_valid,
    input  logic             out_ready,
    output sat_pkg::result_t out_result
);
    import sat_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned SW = $clog2(CAPACITY + 1);
    localparam int unsigned PW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [0:0] {S_RUN, S_SORT} state_t;

    logic [VALUE_W-1:0] ent_reg [CAPACITY];
    logic [VALUE_W-1:0] ent_next [CAPACITY];
    logic [CW-1:0]      count_reg, count_next;
    state_t             state_reg;
    logic [SW-1:0]      pass_reg;
    logic               out_valid_reg, out_valid_next;
    result_t            res_reg, res_next;
    logic               out_free, take;

    logic [CAPACITY-1:0] valid_v, before_v, eq_v, first_eq;
    logic [CW-1:0]       ins_idx, eq_idx, del_idx, ins_pos;
    logic                any_eq, do_ins, do_del;
    logic [PW-1:0]       pos_ext;
    logic [VALUE_W-1:0]  rd_val;
    logic [VALUE_W-1:0]  ins_val;

    function automatic logic precedes(input logic [VALUE_W-1:0] a,
                                      input logic [VALUE_W-1:0] b, input logic desc);
        logic [VALUE_W-1:0] ka, kb;
        ka = a ^ {1'b1, {(VALUE_W-1){1'b0}}};
        kb = b ^ {1'b1, {(VALUE_W-1){1'b0}}};
        precedes = desc ? (ka > kb) : (ka < kb);
    endfunction

    assign out_free = !out_valid_reg || out_ready;
    assign q_ready  = (state_reg == S_RUN) && out_free;
    assign take     = q_valid && q_ready;
    assign out_valid  = out_valid_reg;
    assign out_result = res_reg;
    assign pos_ext    = PW'(q_item.position);

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            valid_v[i]  = (CW'(i) < count_reg);
            before_v[i] = valid_v[i] && precedes(ent_reg[i], q_item.value, descending_order);
            eq_v[i]     = valid_v[i] && (ent_reg[i] == q_item.value);
        end
        first_eq = eq_v & ~(eq_v - 1'b1);
        any_eq   = |eq_v;
        ins_idx  = count_reg;
        eq_idx   = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (valid_v[i] && !before_v[i]) ins_idx = CW'(i);
        end
        for (int i = 0; i < CAPACITY; i++) begin
            if (first_eq[i]) eq_idx = CW'(i);
        end
        rd_val = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (pos_ext == PW'(i)) rd_val = ent_reg[i];
        end
    end

    always_comb begin
        res_next.status      = ST_OK;
        res_next.found       = 1'b0;
        res_next.read_value  = '0;
        count_next           = count_reg;
        do_ins  = 1'b0;
        do_del  = 1'b0;
        ins_pos = ins_idx;
        del_idx = eq_idx;
        ins_val = q_item.value;
        case (q_item.cmd)
            CMD_SORTED_INSERT: begin
                if (count_reg >= CW'(CAPACITY)) res_next.status = ST_FULL;
                else if (any_eq && (ins_idx == eq_idx)) res_next.status = ST_DUP;
                else do_ins = 1'b1;
            end
            CMD_INSERT_AT: begin
                ins_pos = pos_ext[CW-1:0];
                if (count_reg >= CW'(CAPACITY)) res_next.status = ST_FULL;
                else if (pos_ext > PW'(count_reg)) res_next.status = ST_MISS;
                else do_ins = 1'b1;
            end
            CMD_DELETE_VALUE: begin
                if (any_eq) begin
                    res_next.found = 1'b1;
                    do_del = 1'b1;
                end else res_next.status = ST_MISS;
            end
            CMD_DELETE_AT: begin
                del_idx = pos_ext[CW-1:0];
                if (pos_ext < PW'(count_reg)) do_del = 1'b1;
                else res_next.status = ST_MISS;
            end
            CMD_SEARCH: begin
                if (any_eq) res_next.found = 1'b1;
                else res_next.status = ST_MISS;
            end
            CMD_READ: begin
                if (pos_ext < PW'(count_reg)) res_next.read_value = rd_val;
                else res_next.status = ST_MISS;
            end
            CMD_CLEAR: count_next = '0;
            default: ;
        endcase
        if (do_ins) count_next = count_reg + 1'b1;
        if (do_del) count_next = count_reg - 1'b1;
        res_next.entry_count = 5'(count_next);

        for (int i = 0; i < CAPACITY; i++) begin
            ent_next[i] = ent_reg[i];
            if (do_ins) begin
                if (CW'(i) == ins_pos) ent_next[i] = ins_val;
                else if (CW'(i) > ins_pos && i > 0) ent_next[i] = ent_reg[(i > 0) ? i-1 : 0];
            end
            if (do_del && CW'(i) >= del_idx && i < CAPACITY-1) ent_next[i] = ent_reg[i+1];
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !out_ready;
        if (take && (q_item.cmd != CMD_SORT)) out_valid_next = 1'b1;
        if ((state_reg == S_SORT) && (pass_reg == SW'(CAPACITY - 1))) out_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_RUN;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            pass_reg      <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            case (state_reg)
                S_RUN: begin
                    if (take) begin
                        count_reg <= count_next;
                        res_reg   <= res_next;
                        if (q_item.cmd == CMD_SORT) begin
                            state_reg <= S_SORT;
                            pass_reg  <= '0;
                        end
                        for (int i = 0; i < CAPACITY; i++) ent_reg[i] <= ent_next[i];
                    end
                end
                S_SORT: begin
                    for (int i = 0; i + 1 < CAPACITY; i++) begin
                        if ((i[0] == pass_reg[0]) && (CW'(i + 1) < count_reg) &&
                            precedes(ent_reg[i+1], ent_reg[i], descending_order)) begin
                            ent_reg[i]   <= ent_reg[i+1];
                            ent_reg[i+1] <= ent_reg[i];
                        end
                    end
                    pass_reg <= pass_reg + 1'b1;
                    if (pass_reg == SW'(CAPACITY - 1)) begin
                        state_reg <= S_RUN;
                    end
                end
                default: state_reg <= S_RUN;
            endcase
        end
    end
endmodule

### verif/sorted_array_table_test.sv
// Testbench for sorted_array_table: drives commands and configuration writes,
// predicts each result with a scoreboard class. Depends on sat_pkg and the block.
module sorted_array_table_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sat_pkg::*;

    localparam int DEPTH = 16;
    localparam int STEP_LIMIT = 600000;

    class table_scoreboard;
        logic [31:0] cells[DEPTH];
        int unsigned fill;
        bit desc;
        result_t pending[$];
        int errors;

        function new();
            fill = 0;
            desc = 0;
            errors = 0;
        endfunction

        function bit precedes(logic [31:0] a, logic [31:0] b);
            if (desc)
                return $signed(a) > $signed(b);
            return $signed(a) < $signed(b);
        endfunction

        function void shift_in(int unsigned p, logic [31:0] v);
            for (int i = fill; i > p; i--)
                cells[i] = cells[i-1];
            cells[p] = v;
            fill++;
        endfunction

        function void shift_out(int unsigned p);
            for (int i = p; i + 1 < fill; i++)
                cells[i] = cells[i+1];
            fill--;
        endfunction

        function int unsigned locate(logic [31:0] v);
            int unsigned i;
            i = 0;
            while (i < fill && cells[i] != v)
                i++;
            return i;
        endfunction

        function void note_item(item_t it);
            result_t r;
            int unsigned i;
            int j;
            logic [31:0] t;
            r.status = ST_OK;
            r.found = 0;
            r.read_value = '0;
            case (it.cmd)
                CMD_SORTED_INSERT: begin
                    if (fill >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        i = 0;
                        while (i < fill && precedes(cells[i], it.value))
                            i++;
                        if (i < fill && cells[i] == it.value)
                            r.status = ST_DUP;
                        else
                            shift_in(i, it.value);
                    end
                end
                CMD_INSERT_AT: begin
                    if (fill >= DEPTH)
                        r.status = ST_FULL;
                    else if (it.position > fill)
                        r.status = ST_MISS;
                    else
                        shift_in(it.position, it.value);
                end
                CMD_DELETE_VALUE: begin
                    i = locate(it.value);
                    if (i < fill) begin
                        r.found = 1;
                        shift_out(i);
                    end else begin
                        r.status = ST_MISS;
                    end
                end
                CMD_DELETE_AT: begin
                    if (it.position < fill)
                        shift_out(it.position);
                    else
                        r.status = ST_MISS;
                end
                CMD_SEARCH: begin
                    if (locate(it.value) < fill)
                        r.found = 1;
                    else
                        r.status = ST_MISS;
                end
                CMD_READ: begin
                    if (it.position < fill)
                        r.read_value = cells[it.position];
                    else
                        r.status = ST_MISS;
                end
                CMD_CLEAR: fill = 0;
                default: begin
                    for (int k = 1; k < fill; k++) begin
                        t = cells[k];
                        j = k;
                        while (j > 0 && precedes(t, cells[j-1])) begin
                            cells[j] = cells[j-1];
                            j--;
                        end
                        cells[j] = t;
                    end
                end
            endcase
            r.entry_count = 5'(fill);
            pending.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status || got.found !== want.found ||
                got.read_value !== want.read_value ||
                got.entry_count !== want.entry_count) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected st=%0d f=%0d v=%h n=%0d, got st=%0d f=%0d v=%h n=%0d",
                             want.status, want.found, want.read_value, want.entry_count,
                             got.status, got.found, got.read_value, got.entry_count);
            end
        endfunction
    endclass

    logic aclk, aresetn;
    logic cfg_valid, cfg_ready;
    logic [0:0] cfg_data;
    logic s_tvalid, s_tready;
    logic [39:0] s_tdata;
    logic m_tvalid, m_tready;
    logic [39:0] m_tdata;
    table_scoreboard board;
    int cycles;
    int hold_cnt;
    bit done;

    sorted_array_table dut (.*);

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic result_t unpack_result(logic [39:0] d);
        result_t r;
        r.status      = status_t'(d[1:0]);
        r.found       = d[2];
        r.read_value  = d[34:3];
        r.entry_count = d[39:35];
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 24)) - 12);
        endcase
    endfunction

    task automatic send(cmd_t c, logic [31:0] v, logic [3:0] p);
        item_t it;
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge aclk);
        end
        it.cmd = c;
        it.value = v;
        it.position = p;
        s_tdata <= {1'b0, p, v, c};
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
        board.note_item(it);
    endtask

    task automatic write_order(bit d);
        s_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        cfg_data <= d;
        cfg_valid <= 1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        board.desc = d;
    endtask

    task automatic random_item();
        int unsigned w;
        cmd_t c;
        w = $urandom_range(0, 99);
        if (w < 30) c = CMD_SORTED_INSERT;
        else if (w < 45) c = CMD_INSERT_AT;
        else if (w < 57) c = CMD_DELETE_VALUE;
        else if (w < 67) c = CMD_DELETE_AT;
        else if (w < 79) c = CMD_SEARCH;
        else if (w < 92) c = CMD_READ;
        else if (w < 95) c = CMD_CLEAR;
        else c = CMD_SORT;
        send(c, pick_value(), 4'($urandom_range(0, 15)));
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                board.check_result(unpack_result(m_tdata));
            if (hold_cnt > 0) begin
                m_tready <= 1'b0;
                hold_cnt <= hold_cnt - 1;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    hold_cnt <= gap_len();
            end
            cycles <= cycles + 1;
            if (cycles > STEP_LIMIT && !done) begin
                $display("sorted_array_table_test failed");
                $finish;
            end
        end
    end

    initial begin
        board = new();
        cycles = 0;
        hold_cnt = 0;
        done = 0;
        aresetn = 0;
        cfg_valid = 0;
        cfg_data = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        send(CMD_READ, 0, 0);
        send(CMD_DELETE_AT, 0, 15);
        send(CMD_DELETE_VALUE, 5, 0);
        send(CMD_SEARCH, 5, 0);
        send(CMD_SORTED_INSERT, 32'h8000_0000, 0);
        send(CMD_SORTED_INSERT, 32'h7fff_ffff, 0);
        send(CMD_SORTED_INSERT, 32'h7fff_ffff, 0);
        send(CMD_INSERT_AT, 3, 5);
        send(CMD_INSERT_AT, 7, 2);
        send(CMD_INSERT_AT, 7, 0);
        send(CMD_SORT, 0, 0);
        send(CMD_READ, 0, 3);
        send(CMD_SEARCH, 7, 0);
        send(CMD_DELETE_VALUE, 7, 0);
        send(CMD_DELETE_AT, 0, 0);
        for (int k = 0; k < 14; k++)
            send(CMD_INSERT_AT, 32'(k * 3 - 20), 4'($urandom_range(0, 3)));
        send(CMD_SORTED_INSERT, 1, 0);
        send(CMD_INSERT_AT, 1, 0);
        send(CMD_READ, 0, 15);
        send(CMD_CLEAR, 0, 0);
        for (int ph = 0; ph < 4; ph++) begin
            write_order(ph[0] ^ 1'b1);
            for (int n = 0; n < 470; n++)
                random_item();
        end
        s_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        done = 1;
        if (board.errors == 0)
            $display("sorted_array_table_test passed");
        else
            $display("sorted_array_table_test failed");
        $finish;
    end
endmodule
